@@ rtl/lcbd_pkg.sv @@
// Package for the link command byte decoder.
// Holds the command classes, payload kinds, text actions and queue item type.
// No dependencies.
package lcbd_pkg;

  localparam int VERSION_BYTES_DEF = 8;
  localparam int ADDRESS_BYTES_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] STATUS_REQ_BYTE = 8'h50;
  localparam logic [7:0] POWERON_REQ_BYTE = 8'h60;
  localparam logic [7:0] POWERON_SET_BYTE = 8'h61;
  localparam logic [2:0] STAGE_MAX = 3'd5;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ARM,
    CMD_ACK,
    CMD_STAGE,
    CMD_VER_HDR,
    CMD_ADDR_HDR,
    CMD_STATUS_REQ,
    CMD_STATUS_SET,
    CMD_PWR_REQ,
    CMD_PWR_SET
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_VERSION,
    KIND_ADDRESS
  } kind_t;

  typedef enum logic [2:0] {
    TEXT_NONE,
    TEXT_VER_BYTE,
    TEXT_ADDR_BYTE,
    TEXT_CLR_VER,
    TEXT_CLR_ADDR
  } text_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
  } item_t;

endpackage

@@ rtl/link_command_byte_decoder_unit.sv @@
// Top level of the link command byte decoder.
// Instantiates lcbd_front, lcbd_queue and lcbd_back; depends on lcbd_pkg.
//
// The block takes one received link byte or one arm request per cycle while
// in_stall is low and returns exactly one result per request, in order. A
// request is classified on entry, written into a two-entry queue, and carried
// out by the back end, which updates its state and registers the result when
// it pops the request from the queue; the sustained rate is one request per
// cycle when the output is not stalled. The queue absorbs short output stalls;
// in_stall rises only when it is full.
module link_command_byte_decoder_unit import lcbd_pkg::*; #(
  parameter int VERSION_BYTES = VERSION_BYTES_DEF,
  parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] stage,
  output logic       stage_changed,
  output logic       value_changed,
  output logic       status_request,
  output logic       poweron_request,
  output logic       save_settings,
  output logic [1:0] boot_slot,
  output logic [2:0] status_flags,
  output logic [2:0] text_action,
  output logic [3:0] text_index,
  output logic [7:0] text_byte,
  output logic       ack_pending
);

  item_t front_item;
  item_t q_head;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  push;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  lcbd_front u_front (
    .action    (action),
    .data_byte (data_byte),
    .item      (front_item)
  );

  lcbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lcbd_back #(
    .VERSION_BYTES (VERSION_BYTES),
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .stage           (stage),
    .stage_changed   (stage_changed),
    .value_changed   (value_changed),
    .status_request  (status_request),
    .poweron_request (poweron_request),
    .save_settings   (save_settings),
    .boot_slot       (boot_slot),
    .status_flags    (status_flags),
    .text_action     (text_action),
    .text_index      (text_index),
    .text_byte       (text_byte),
    .ack_pending     (ack_pending)
  );

  a_text_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_action != TEXT_VER_BYTE && text_action != TEXT_ADDR_BYTE
      |-> text_index == '0 && text_byte == '0)
    else $error("text index or byte set without a payload write");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({stage_changed, status_request, poweron_request, save_settings}))
    else $error("more than one command pulse in a result");

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stage <= STAGE_MAX)
    else $error("stage out of range");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("queue read while empty");

endmodule

@@ rtl/lcbd_front.sv @@
// Front end of the link command byte decoder: classifies each received byte.
// Depends on lcbd_pkg.
module lcbd_front import lcbd_pkg::*; (
  input  logic       action,
  input  logic [7:0] data_byte,
  output item_t      item
);

  logic [3:0] hi;
  logic [3:0] lo;

  assign hi = data_byte[7:4];
  assign lo = data_byte[3:0];

  always_comb begin
    item.data_byte = data_byte;
    item.cmd = CMD_NONE;
    if (action) begin
      item.cmd = CMD_ARM;
    end else begin
      case (hi)
        4'h1: item.cmd = CMD_ACK;
        4'h2: item.cmd = CMD_STAGE;
        4'h3: item.cmd = (lo inside {4'h0, 4'h1}) ? CMD_NONE : CMD_VER_HDR;
        4'h4: item.cmd = CMD_ADDR_HDR;
        4'h5: item.cmd = (data_byte == STATUS_REQ_BYTE) ? CMD_STATUS_REQ : CMD_STATUS_SET;
        4'h6: item.cmd = (data_byte == POWERON_REQ_BYTE) ? CMD_PWR_REQ : CMD_PWR_SET;
        default: item.cmd = CMD_NONE;
      endcase
    end
  end

endmodule

@@ rtl/lcbd_queue.sv @@
// Short request queue between the front and back of the decoder.
// Depends on lcbd_pkg.
module lcbd_queue import lcbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t         store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign head = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lcbd_back.sv @@
// Back end of the decoder: holds the link state, carries out each request
// and keeps the registered result. Depends on lcbd_pkg.
module lcbd_back import lcbd_pkg::*; #(
  parameter int VERSION_BYTES = VERSION_BYTES_DEF,
  parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_not_empty,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] stage,
  output logic       stage_changed,
  output logic       value_changed,
  output logic       status_request,
  output logic       poweron_request,
  output logic       save_settings,
  output logic [1:0] boot_slot,
  output logic [2:0] status_flags,
  output logic [2:0] text_action,
  output logic [3:0] text_index,
  output logic [7:0] text_byte,
  output logic       ack_pending
);

  localparam logic [4:0] VER_COUNT = 5'(VERSION_BYTES);
  localparam logic [4:0] ADDR_COUNT = 5'(ADDRESS_BYTES);

  logic [7:0] awaited_command, awaited_command_next;
  logic [4:0] payload_remaining, payload_remaining_next;
  kind_t      payload_kind, payload_kind_next;
  logic [3:0] version_write_index, version_write_index_next;
  logic [2:0] stage_reg, stage_reg_next;
  logic [1:0] slot_reg, slot_reg_next;
  logic [2:0] flags_reg, flags_reg_next;

  logic       stage_chg, val_chg, st_req, po_req, save;
  text_t      t_act;
  logic [3:0] t_idx;
  logic [7:0] t_byte;
  logic [7:0] b;
  logic [3:0] lo;
  logic [4:0] rem_dec;
  logic [4:0] addr_pos;

  assign q_pop = q_not_empty && (!out_valid || !out_stall);
  assign b = q_head.data_byte;
  assign lo = b[3:0];
  assign rem_dec = payload_remaining - 5'd1;
  assign addr_pos = ADDR_COUNT - payload_remaining;

  always_comb begin
    awaited_command_next = awaited_command;
    payload_remaining_next = payload_remaining;
    payload_kind_next = payload_kind;
    version_write_index_next = version_write_index;
    stage_reg_next = stage_reg;
    slot_reg_next = slot_reg;
    flags_reg_next = flags_reg;
    stage_chg = 1'b0;
    val_chg = 1'b0;
    st_req = 1'b0;
    po_req = 1'b0;
    save = 1'b0;
    t_act = TEXT_NONE;
    t_idx = '0;
    t_byte = '0;
    if (q_head.cmd == CMD_ARM) begin
      awaited_command_next = b;
    end else if (payload_remaining != '0) begin
      case (payload_kind)
        KIND_VERSION: begin
          payload_remaining_next = rem_dec;
          if (b != '0) begin
            t_act = TEXT_VER_BYTE;
            t_idx = version_write_index;
            t_byte = b;
            version_write_index_next = version_write_index + 4'd1;
          end
        end
        KIND_ADDRESS: begin
          payload_remaining_next = rem_dec;
          t_act = TEXT_ADDR_BYTE;
          t_idx = addr_pos[3:0];
          t_byte = b;
        end
        default: payload_remaining_next = '0;
      endcase
      val_chg = (payload_remaining_next == '0);
    end else begin
      case (q_head.cmd)
        CMD_ACK: begin
          if (awaited_command != '0 && lo == awaited_command[7:4]) begin
            awaited_command_next = '0;
          end
        end
        CMD_STAGE: begin
          stage_reg_next = (lo <= 4'(STAGE_MAX)) ? lo[2:0] : 3'd0;
          stage_chg = 1'b1;
        end
        CMD_VER_HDR: begin
          t_act = TEXT_CLR_VER;
          payload_remaining_next = VER_COUNT;
          payload_kind_next = KIND_VERSION;
          version_write_index_next = '0;
        end
        CMD_ADDR_HDR: begin
          t_act = TEXT_CLR_ADDR;
          payload_remaining_next = ADDR_COUNT;
          payload_kind_next = KIND_ADDRESS;
        end
        CMD_STATUS_REQ: st_req = 1'b1;
        CMD_STATUS_SET: begin
          if (b[3:2] != '0) begin
            slot_reg_next = b[3:2];
          end
          flags_reg_next = {flags_reg[2], b[1:0]};
          save = 1'b1;
          val_chg = 1'b1;
        end
        CMD_PWR_REQ: po_req = 1'b1;
        CMD_PWR_SET: begin
          flags_reg_next = {(b == POWERON_SET_BYTE), flags_reg[1:0]};
          save = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaited_command <= '0;
      payload_remaining <= '0;
      payload_kind <= KIND_NONE;
      version_write_index <= '0;
      stage_reg <= '0;
      slot_reg <= '0;
      flags_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        awaited_command <= awaited_command_next;
        payload_remaining <= payload_remaining_next;
        payload_kind <= payload_kind_next;
        version_write_index <= version_write_index_next;
        stage_reg <= stage_reg_next;
        slot_reg <= slot_reg_next;
        flags_reg <= flags_reg_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      stage <= stage_reg_next;
      stage_changed <= stage_chg;
      value_changed <= val_chg;
      status_request <= st_req;
      poweron_request <= po_req;
      save_settings <= save;
      boot_slot <= slot_reg_next;
      status_flags <= flags_reg_next;
      text_action <= t_act;
      text_index <= t_idx;
      text_byte <= t_byte;
      ack_pending <= (awaited_command_next != '0);
    end
  end

endmodule
